>>> rtl/evm_basic_block_splitter_assert.svh
// Assertion macros shared by the basic block splitter checks.
`ifndef EVM_BASIC_BLOCK_SPLITTER_ASSERT_SVH
`define EVM_BASIC_BLOCK_SPLITTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EBBS_ASSERT_SAME(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("assertion failed: %m");

// The consequent must hold in the cycle after the antecedent.
`define EBBS_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("assertion failed: %m");

`endif

>>> rtl/ebbs_pkg.sv
// Package with opcodes, record codes and field widths of the basic block splitter.
package ebbs_pkg;

   localparam int OFFSET_BITS_DEF = 16;
   localparam int BLOCK_W = 16;
   localparam int COUNT_W = 16;
   localparam int ENDK_W  = 3;
   localparam int PAD_W   = 6;
   localparam int SKIP_W  = 6;
   localparam int KIND_W  = 2;

   localparam logic [7:0] OP_STOP         = 8'h00;
   localparam logic [7:0] OP_JUMP         = 8'h56;
   localparam logic [7:0] OP_JUMPI        = 8'h57;
   localparam logic [7:0] OP_JUMPDEST     = 8'h5B;
   localparam logic [7:0] OP_PUSH1        = 8'h60;
   localparam logic [7:0] OP_PUSH32       = 8'h7F;
   localparam logic [7:0] OP_RETURN       = 8'hF3;
   localparam logic [7:0] OP_REVERT       = 8'hFD;
   localparam logic [7:0] OP_SELFDESTRUCT = 8'hFF;

   localparam logic [BLOCK_W-1:0] BLOCK_SAT = '1;
   localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

   typedef enum logic [KIND_W-1:0] {
      KIND_BLOCK = 2'd0,
      KIND_DEST  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   typedef enum logic [ENDK_W-1:0] {
      END_STOP         = 3'd0,
      END_JUMP         = 3'd1,
      END_JUMPI        = 3'd2,
      END_RETURN       = 3'd3,
      END_REVERT       = 3'd4,
      END_SELFDESTRUCT = 3'd5,
      END_JUMPDEST     = 3'd6
   } end_kind_type;

endpackage

>>> rtl/evm_basic_block_splitter.sv
// Basic block splitter for EVM bytecode, one code byte per request.
//
//   channel  direction  tdata                      tuser        tlast
//   req      in         code_byte                  -            final_byte
//   rsp      out        block/dest/end record      record_kind  run_last
//
// A request is decoded in the cycle it is accepted and its up to four records are
// written into a record buffer; they leave through the output register, one per cycle
// unless rsp stalls. A byte that yields zero or one record allows a new request every
// cycle unless rsp stalls; one that yields more holds the request side until its last
// record moves into the output register. The first record reaches rsp through the
// buffer and the output register. Reset is synchronous, clears the decoder state and
// empties the buffer and the output register. A stalled rsp holds its record.
module evm_basic_block_splitter #(
   parameter int OFFSET_BITS = ebbs_pkg::OFFSET_BITS_DEF,
   localparam int RAW_W = 2 * ebbs_pkg::BLOCK_W + ebbs_pkg::COUNT_W + ebbs_pkg::ENDK_W + 1
                          + ebbs_pkg::PAD_W + 2 * OFFSET_BITS + 1,
   localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // req_tdata: code_byte[7:0].
   input  logic [7:0]                  req_tdata,
   input  logic                        req_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // rsp_tdata from bit 0 up: block_number, block_start, instr_count, end_kind,
   // has_fallthrough, fallthrough_block, dest_offset, pad_bytes, zero fill.
   output logic [DATA_W-1:0]           rsp_tdata,
   // rsp_tuser: record_kind.
   output logic [ebbs_pkg::KIND_W-1:0] rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int BW = ebbs_pkg::BLOCK_W;
   localparam int CW = ebbs_pkg::COUNT_W;
   localparam int SW = ebbs_pkg::SKIP_W;

   logic                 inside_ff, inside_in;
   logic [SW-1:0]        skip_ff, skip_in;
   logic [OFFSET_BITS:0] pos_ff, pos_in;
   logic [BW-1:0]        block_ff, block_in;
   logic [OFFSET_BITS:0] start_ff, start_in;
   logic [CW-1:0]        count_ff, count_in;

   logic [DATA_W-1:0]  rec_data_ff [4];
   logic [DATA_W-1:0]  rec_data_in [4];
   ebbs_pkg::kind_type rec_kind_ff [4];
   ebbs_pkg::kind_type rec_kind_in [4];
   logic               rec_last_ff [4];
   logic               rec_last_in [4];
   logic [2:0]         rec_num;

   logic [2:0] batch_cnt_ff, batch_cnt_in;
   logic [1:0] batch_rd_ff, batch_rd_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   ebbs_pkg::kind_type rsp_kind_ff, rsp_kind_in;
   logic               rsp_last_ff, rsp_last_in;

   logic load_out;
   logic accept;

   function automatic logic [DATA_W-1:0] pack_record(
      input logic [BW-1:0]                 blk,
      input logic [OFFSET_BITS:0]          start,
      input logic [CW-1:0]                 cnt,
      input ebbs_pkg::end_kind_type        endk,
      input logic                          ft,
      input logic [BW-1:0]                 ftb,
      input logic [OFFSET_BITS-1:0]        dest,
      input logic [ebbs_pkg::PAD_W-1:0]    pad
   );
      return DATA_W'({pad, dest, ftb, ft, endk, cnt, start, blk});
   endfunction

   always_comb begin
      logic [7:0]             code;
      logic                   fin;
      logic [OFFSET_BITS:0]   next_pos;
      logic [BW-1:0]          next_id;
      logic [OFFSET_BITS-1:0] dest;
      logic [2:0]             last_idx;
      ebbs_pkg::end_kind_type endk;

      code     = req_tdata;
      fin      = req_tlast;
      next_pos = pos_ff[OFFSET_BITS] ? pos_ff : pos_ff + 1'b1;
      next_id  = (block_ff == ebbs_pkg::BLOCK_SAT) ? block_ff : block_ff + 1'b1;
      dest     = pos_ff[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : pos_ff[OFFSET_BITS-1:0];
      endk     = ebbs_pkg::END_STOP;

      inside_in = inside_ff;
      skip_in   = skip_ff;
      block_in  = block_ff;
      start_in  = start_ff;
      count_in  = count_ff;
      rec_num   = 3'd0;
      for (int i = 0; i < 4; i++) begin
         rec_data_in[i] = '0;
         rec_kind_in[i] = ebbs_pkg::KIND_BLOCK;
         rec_last_in[i] = 1'b0;
      end

      if (skip_ff != '0) begin
         skip_in = skip_ff - 1'b1;
      end else begin
         if (!inside_in) begin
            if (code == ebbs_pkg::OP_JUMPDEST) begin
               block_in  = next_id;
               start_in  = next_pos;
               count_in  = '0;
               inside_in = 1'b1;
               rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_DEST;
               rec_data_in[rec_num[1:0]] = pack_record(block_in, '0, '0,
                  ebbs_pkg::END_STOP, 1'b0, '0, dest, '0);
               rec_num = rec_num + 3'd1;
            end
         end else if (code == ebbs_pkg::OP_JUMPDEST) begin
            if (count_in != '0) begin
               rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_BLOCK;
               rec_data_in[rec_num[1:0]] = pack_record(block_in, start_in, count_in,
                  ebbs_pkg::END_JUMPDEST, 1'b1, next_id, '0, '0);
               rec_num  = rec_num + 3'd1;
               block_in = next_id;
               start_in = next_pos;
               count_in = '0;
            end else if (!start_in[OFFSET_BITS]) begin
               start_in = start_in + 1'b1;
            end
            rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_DEST;
            rec_data_in[rec_num[1:0]] = pack_record(block_in, '0, '0,
               ebbs_pkg::END_STOP, 1'b0, '0, dest, '0);
            rec_num = rec_num + 3'd1;
         end else if (code == ebbs_pkg::OP_JUMPI) begin
            rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_BLOCK;
            rec_data_in[rec_num[1:0]] = pack_record(block_in, start_in, count_in,
               ebbs_pkg::END_JUMPI, 1'b1, next_id, '0, '0);
            rec_num  = rec_num + 3'd1;
            block_in = next_id;
            start_in = next_pos;
            count_in = '0;
         end else if (code == ebbs_pkg::OP_STOP || code == ebbs_pkg::OP_JUMP ||
                      code == ebbs_pkg::OP_RETURN || code == ebbs_pkg::OP_REVERT ||
                      code == ebbs_pkg::OP_SELFDESTRUCT) begin
            unique case (code)
               ebbs_pkg::OP_JUMP:         endk = ebbs_pkg::END_JUMP;
               ebbs_pkg::OP_RETURN:       endk = ebbs_pkg::END_RETURN;
               ebbs_pkg::OP_REVERT:       endk = ebbs_pkg::END_REVERT;
               ebbs_pkg::OP_SELFDESTRUCT: endk = ebbs_pkg::END_SELFDESTRUCT;
               default:                   endk = ebbs_pkg::END_STOP;
            endcase
            rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_BLOCK;
            rec_data_in[rec_num[1:0]] = pack_record(block_in, start_in, count_in,
               endk, 1'b0, '0, '0, '0);
            rec_num   = rec_num + 3'd1;
            inside_in = 1'b0;
         end else if (count_in != ebbs_pkg::COUNT_SAT) begin
            count_in = count_in + 1'b1;
         end
         if (code >= ebbs_pkg::OP_PUSH1 && code <= ebbs_pkg::OP_PUSH32) begin
            skip_in = {1'b0, code[4:0]} + 1'b1;
         end
      end
      pos_in = next_pos;

      if (fin) begin
         if (inside_in) begin
            rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_BLOCK;
            rec_data_in[rec_num[1:0]] = pack_record(block_in, start_in, count_in,
               ebbs_pkg::END_STOP, 1'b0, '0, '0, '0);
            rec_num = rec_num + 3'd1;
         end
         rec_kind_in[rec_num[1:0]] = ebbs_pkg::KIND_END;
         rec_data_in[rec_num[1:0]] = pack_record(block_in, '0, '0,
            ebbs_pkg::END_STOP, 1'b0, '0, '0, skip_in);
         rec_num   = rec_num + 3'd1;
         inside_in = 1'b1;
         skip_in   = '0;
         pos_in    = '0;
         block_in  = '0;
         start_in  = '0;
         count_in  = '0;
      end

      last_idx = rec_num - 3'd1;
      if (rec_num != 3'd0) begin
         rec_last_in[last_idx[1:0]] = 1'b1;
      end
   end

   always_comb begin
      load_out   = (batch_cnt_ff != 3'd0) && (!rsp_valid_ff || rsp_tready);
      req_tready = (batch_cnt_ff == 3'd0) || ((batch_cnt_ff == 3'd1) && load_out);
      accept     = req_tvalid && req_tready;

      batch_cnt_in = batch_cnt_ff;
      batch_rd_in  = batch_rd_ff;
      if (accept) begin
         batch_cnt_in = rec_num;
         batch_rd_in  = 2'd0;
      end else if (load_out) begin
         batch_cnt_in = batch_cnt_ff - 3'd1;
         batch_rd_in  = batch_rd_ff + 2'd1;
      end

      rsp_data_in = rsp_data_ff;
      rsp_kind_in = rsp_kind_ff;
      rsp_last_in = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = rec_data_ff[batch_rd_ff];
         rsp_kind_in  = rec_kind_ff[batch_rd_ff];
         rsp_last_in  = rec_last_ff[batch_rd_ff];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff    <= 1'b1;
         skip_ff      <= '0;
         pos_ff       <= '0;
         block_ff     <= '0;
         start_ff     <= '0;
         count_ff     <= '0;
         batch_cnt_ff <= 3'd0;
         batch_rd_ff  <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            inside_ff <= inside_in;
            skip_ff   <= skip_in;
            pos_ff    <= pos_in;
            block_ff  <= block_in;
            start_ff  <= start_in;
            count_ff  <= count_in;
         end
         batch_cnt_ff <= batch_cnt_in;
         batch_rd_ff  <= batch_rd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 4; i++) begin
            rec_data_ff[i] <= rec_data_in[i];
            rec_kind_ff[i] <= rec_kind_in[i];
            rec_last_ff[i] <= rec_last_in[i];
         end
      end
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> rtl/ebbs_checker.sv
// Port checks for the basic block splitter and their binding to the top level.
`include "evm_basic_block_splitter_assert.svh"

module ebbs_checker #(
   parameter int OFFSET_BITS = ebbs_pkg::OFFSET_BITS_DEF,
   localparam int RAW_W = 2 * ebbs_pkg::BLOCK_W + ebbs_pkg::COUNT_W + ebbs_pkg::ENDK_W + 1
                          + ebbs_pkg::PAD_W + 2 * OFFSET_BITS + 1,
   localparam int DATA_W = ((RAW_W + 7) / 8) * 8
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [DATA_W-1:0]           rsp_tdata,
   input logic [ebbs_pkg::KIND_W-1:0] rsp_tuser,
   input logic                        rsp_tlast
);

   localparam int FT_BIT  = ebbs_pkg::BLOCK_W + OFFSET_BITS + 1 + ebbs_pkg::COUNT_W
                            + ebbs_pkg::ENDK_W;
   localparam int FTB_LSB = FT_BIT + 1;

   logic                        is_block;
   logic                        is_dest;
   logic                        is_end;
   logic                        has_ft;
   logic [ebbs_pkg::BLOCK_W-1:0] blk;
   logic [ebbs_pkg::BLOCK_W-1:0] ftb;

   assign is_block = rsp_tvalid && (rsp_tuser == ebbs_pkg::KIND_BLOCK);
   assign is_dest  = rsp_tvalid && (rsp_tuser == ebbs_pkg::KIND_DEST);
   assign is_end   = rsp_tvalid && (rsp_tuser == ebbs_pkg::KIND_END);
   assign has_ft   = rsp_tdata[FT_BIT];
   assign blk      = rsp_tdata[ebbs_pkg::BLOCK_W-1:0];
   assign ftb      = rsp_tdata[FTB_LSB +: ebbs_pkg::BLOCK_W];

   `EBBS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
   `EBBS_ASSERT_SAME(a_end_closes_run, clock, reset, is_end, rsp_tlast)
   `EBBS_ASSERT_SAME(a_dest_no_fallthrough, clock, reset, is_dest, !has_ft)
   `EBBS_ASSERT_SAME(a_fallthrough_next_id, clock, reset,
      is_block && has_ft && (blk != ebbs_pkg::BLOCK_SAT), ftb == blk + 1'b1)

endmodule

bind evm_basic_block_splitter ebbs_checker #(
   .OFFSET_BITS(OFFSET_BITS)
) u_ebbs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

>>> dv/tb_evm_basic_block_splitter.sv
// Self-checking testbench for the EVM basic block splitter.
`timescale 1ns / 100ps

module tb_evm_basic_block_splitter;

   localparam int OFS = ebbs_pkg::OFFSET_BITS_DEF;
   localparam int PAD_W = ebbs_pkg::PAD_W;
   localparam int BLOCK_W = ebbs_pkg::BLOCK_W;
   localparam int COUNT_W = ebbs_pkg::COUNT_W;
   localparam int SKIP_W = ebbs_pkg::SKIP_W;
   localparam int KIND_W = ebbs_pkg::KIND_W;
   localparam logic [OFS:0] POS_LIMIT = {1'b1, {OFS{1'b0}}};
   localparam int RANDOM_BYTES = 50;

   typedef struct packed {
      logic [PAD_W-1:0]       pad;
      logic [OFS-1:0]         dest;
      logic [BLOCK_W-1:0]     ft_block;
      logic                   ft;
      ebbs_pkg::end_kind_type endk;
      logic [COUNT_W-1:0]     count;
      logic [OFS:0]           start;
      logic [BLOCK_W-1:0]     blk;
   } record_fields_type;

   localparam int REC_W = $bits(record_fields_type);
   localparam int DATA_W = ((REC_W + 7) / 8) * 8;

   typedef struct {
      ebbs_pkg::kind_type kind;
      record_fields_type  f;
      logic               last;
   } expected_record_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_SPARSE
   } ready_mode_type;

   localparam logic [7:0] TERMINATORS [5] = '{ebbs_pkg::OP_STOP, ebbs_pkg::OP_JUMP,
      ebbs_pkg::OP_RETURN, ebbs_pkg::OP_REVERT, ebbs_pkg::OP_SELFDESTRUCT};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = 8'h00;
   logic              req_tlast = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0] rsp_tuser;
   logic              rsp_tlast;

   // Predicted decoder state.
   logic               in_block;
   logic [SKIP_W-1:0]  skip_left;
   logic [OFS:0]       byte_pos;
   logic [BLOCK_W-1:0] cur_block;
   logic [OFS:0]       cur_start;
   logic [COUNT_W-1:0] cur_count;

   expected_record_type expected_records[$];
   expected_record_type want_rec;
   record_fields_type   got_rec;

   int             mismatch_count = 0;
   int             records_seen = 0;
   int             bytes_sent = 0;
   int             programs_sent = 0;
   int             burst_left = 0;
   bit             gaps_on = 1'b0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int             hold_request = 0;
   int             hold_left = 0;
   int             pattern_step = 0;

   evm_basic_block_splitter uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   function automatic expected_record_type make_record(ebbs_pkg::kind_type kind,
         logic [BLOCK_W-1:0] blk, logic [OFS:0] start, logic [COUNT_W-1:0] count,
         ebbs_pkg::end_kind_type endk, logic ft, logic [BLOCK_W-1:0] ft_block,
         logic [OFS-1:0] dest, logic [PAD_W-1:0] pad);
      expected_record_type r;
      r.kind = kind;
      r.f.blk = blk;
      r.f.start = start;
      r.f.count = count;
      r.f.endk = endk;
      r.f.ft = ft;
      r.f.ft_block = ft_block;
      r.f.dest = dest;
      r.f.pad = pad;
      r.last = 1'b0;
      return r;
   endfunction

   task automatic clear_splitter_state();
      in_block = 1'b1;
      skip_left = '0;
      byte_pos = '0;
      cur_block = '0;
      cur_start = '0;
      cur_count = '0;
   endtask

   task automatic predict_block_records(input logic [7:0] code, input logic fin);
      logic [OFS:0]           next_pos;
      logic [BLOCK_W-1:0]     next_id;
      logic [OFS-1:0]         dest;
      ebbs_pkg::end_kind_type term;
      expected_record_type    batch[$];
      next_pos = (byte_pos < POS_LIMIT) ? byte_pos + 1'b1 : POS_LIMIT;
      next_id = (cur_block != ebbs_pkg::BLOCK_SAT) ? cur_block + 1'b1 : ebbs_pkg::BLOCK_SAT;
      dest = (byte_pos < POS_LIMIT) ? byte_pos[OFS-1:0] : '1;
      if (skip_left != 0) begin
         skip_left--;
      end else begin
         if (!in_block) begin
            if (code == ebbs_pkg::OP_JUMPDEST) begin
               cur_block = next_id;
               cur_start = next_pos;
               cur_count = '0;
               in_block = 1'b1;
               batch.push_back(make_record(ebbs_pkg::KIND_DEST, cur_block, '0, '0,
                                           ebbs_pkg::END_STOP, 1'b0, '0, dest, '0));
            end
         end else if (code == ebbs_pkg::OP_JUMPDEST) begin
            if (cur_count != 0) begin
               batch.push_back(make_record(ebbs_pkg::KIND_BLOCK, cur_block, cur_start,
                                           cur_count, ebbs_pkg::END_JUMPDEST, 1'b1, next_id,
                                           '0, '0));
               cur_block = next_id;
               cur_start = next_pos;
               cur_count = '0;
            end else if (cur_start < POS_LIMIT) begin
               cur_start++;
            end
            batch.push_back(make_record(ebbs_pkg::KIND_DEST, cur_block, '0, '0,
                                        ebbs_pkg::END_STOP, 1'b0, '0, dest, '0));
         end else if (code == ebbs_pkg::OP_JUMPI) begin
            batch.push_back(make_record(ebbs_pkg::KIND_BLOCK, cur_block, cur_start, cur_count,
                                        ebbs_pkg::END_JUMPI, 1'b1, next_id, '0, '0));
            cur_block = next_id;
            cur_start = next_pos;
            cur_count = '0;
         end else if (code inside {ebbs_pkg::OP_STOP, ebbs_pkg::OP_JUMP, ebbs_pkg::OP_RETURN,
                                   ebbs_pkg::OP_REVERT, ebbs_pkg::OP_SELFDESTRUCT}) begin
            unique case (code)
               ebbs_pkg::OP_JUMP: term = ebbs_pkg::END_JUMP;
               ebbs_pkg::OP_RETURN: term = ebbs_pkg::END_RETURN;
               ebbs_pkg::OP_REVERT: term = ebbs_pkg::END_REVERT;
               ebbs_pkg::OP_SELFDESTRUCT: term = ebbs_pkg::END_SELFDESTRUCT;
               default: term = ebbs_pkg::END_STOP;
            endcase
            batch.push_back(make_record(ebbs_pkg::KIND_BLOCK, cur_block, cur_start, cur_count,
                                        term, 1'b0, '0, '0, '0));
            in_block = 1'b0;
         end else if (cur_count != ebbs_pkg::COUNT_SAT) begin
            cur_count++;
         end
         if (code >= ebbs_pkg::OP_PUSH1 && code <= ebbs_pkg::OP_PUSH32) begin
            skip_left = SKIP_W'(code - ebbs_pkg::OP_PUSH1 + 1);
         end
      end
      byte_pos = next_pos;
      if (fin) begin
         if (in_block) begin
            batch.push_back(make_record(ebbs_pkg::KIND_BLOCK, cur_block, cur_start, cur_count,
                                        ebbs_pkg::END_STOP, 1'b0, '0, '0, '0));
         end
         batch.push_back(make_record(ebbs_pkg::KIND_END, cur_block, '0, '0,
                                     ebbs_pkg::END_STOP, 1'b0, '0, '0, PAD_W'(skip_left)));
         clear_splitter_state();
      end
      if (batch.size() != 0) begin
         batch[batch.size() - 1].last = 1'b1;
      end
      foreach (batch[i]) begin
         expected_records.push_back(batch[i]);
      end
   endtask

   task automatic send_byte(input logic [7:0] code, input logic fin);
      int gap;
      @(negedge clock);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = $urandom_range(1, 6);
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left--;
      end
      req_tvalid <= 1'b1;
      req_tdata <= code;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      predict_block_records(code, fin);
      bytes_sent++;
   endtask

   task automatic send_program(input logic [7:0] prog[$]);
      foreach (prog[i]) begin
         send_byte(prog[i], i == prog.size() - 1);
      end
      programs_sent++;
   endtask

   task automatic wait_for_records();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_records.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_program(input bit noise);
      int         len;
      int         n;
      int         pick;
      int         args;
      logic [7:0] op;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 20);
      n = 0;
      while (n < len) begin
         args = 0;
         pick = $urandom_range(0, 99);
         if (noise || pick >= 45) begin
            op = 8'($urandom);
         end else if (pick < 12) begin
            op = ebbs_pkg::OP_JUMPDEST;
         end else if (pick < 18) begin
            op = ebbs_pkg::OP_JUMPI;
         end else if (pick < 26) begin
            op = TERMINATORS[$urandom_range(0, 4)];
         end else begin
            args = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 4);
            op = 8'(ebbs_pkg::OP_PUSH1 + args - 1);
         end
         send_byte(op, n == len - 1);
         n++;
         while (args > 0 && n < len) begin
            op = ($urandom_range(0, 3) == 0) ? ebbs_pkg::OP_JUMPDEST : 8'($urandom);
            send_byte(op, n == len - 1);
            n++;
            args--;
         end
      end
      programs_sent++;
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         records_seen++;
         if (expected_records.size() == 0) begin
            $display("%0t: unexpected record, expected none, actual kind %0d data 0x%0h",
                     $time, rsp_tuser, rsp_tdata);
            mismatch_count++;
         end else begin
            want_rec = expected_records.pop_front();
            got_rec = record_fields_type'(rsp_tdata[REC_W-1:0]);
            check_field("record_kind", want_rec.kind, rsp_tuser);
            check_field("block_number", want_rec.f.blk, got_rec.blk);
            check_field("block_start", want_rec.f.start, got_rec.start);
            check_field("instr_count", want_rec.f.count, got_rec.count);
            check_field("end_kind", want_rec.f.endk, got_rec.endk);
            check_field("has_fallthrough", want_rec.f.ft, got_rec.ft);
            check_field("fallthrough_block", want_rec.f.ft_block, got_rec.ft_block);
            check_field("dest_offset", want_rec.f.dest, got_rec.dest);
            check_field("pad_bytes", want_rec.f.pad, got_rec.pad);
            check_field("run_last", want_rec.last, rsp_tlast);
            check_field("zero fill", '0, 32'(rsp_tdata >> REC_W));
         end
      end
   end

   // A hold request from the test loads hold_left, which keeps rsp_tready low until it counts down to zero.
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         pattern_step++;
         case (ready_mode)
            READY_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: rsp_tready <= ((pattern_step % 7) < 4);
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= 1'b1;
         endcase
      end
   end

   task automatic test_every_opcode();
      gaps_on = 1'b1;
      ready_mode = READY_RANDOM;
      send_program('{8'h01, 8'h02, ebbs_pkg::OP_JUMPDEST, ebbs_pkg::OP_JUMPDEST, 8'h0C,
                     ebbs_pkg::OP_JUMPI, 8'h03, ebbs_pkg::OP_STOP, 8'h01,
                     ebbs_pkg::OP_JUMPDEST, 8'h01, ebbs_pkg::OP_JUMP, ebbs_pkg::OP_PUSH1,
                     ebbs_pkg::OP_JUMPDEST, ebbs_pkg::OP_JUMPDEST, ebbs_pkg::OP_RETURN,
                     ebbs_pkg::OP_JUMPDEST, ebbs_pkg::OP_REVERT, ebbs_pkg::OP_JUMPDEST, 8'hFE,
                     ebbs_pkg::OP_SELFDESTRUCT, 8'hFF});
      send_program('{8'h01, ebbs_pkg::OP_PUSH32, ebbs_pkg::OP_JUMPDEST, 8'hAA});
      send_program('{ebbs_pkg::OP_PUSH32});
      send_program('{ebbs_pkg::OP_PUSH1});
      send_program('{8'h01, ebbs_pkg::OP_JUMPDEST});
      send_program('{ebbs_pkg::OP_JUMPDEST});
      send_program('{ebbs_pkg::OP_JUMPI});
      wait_for_records();
   endtask

   task automatic test_push_skipping();
      int width;
      gaps_on = 1'b1;
      ready_mode = READY_PATTERN;
      for (width = 1; width <= 32; width += 31) begin
         send_byte(8'h01, 1'b0);
         send_byte(8'(ebbs_pkg::OP_PUSH1 + width - 1), 1'b0);
         repeat (width) send_byte(ebbs_pkg::OP_JUMPDEST, 1'b0);
         send_byte(ebbs_pkg::OP_STOP, 1'b0);
         send_byte(8'(ebbs_pkg::OP_PUSH1 + width - 1), 1'b0);
         repeat (width) send_byte(ebbs_pkg::OP_JUMPDEST, 1'b0);
         send_byte(ebbs_pkg::OP_JUMPDEST, 1'b1);
         programs_sent++;
      end
      wait_for_records();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      ready_mode = READY_ALWAYS;
      hold_request = 400;
      repeat (40) begin
         send_byte(8'h01, 1'b0);
         send_byte(ebbs_pkg::OP_JUMPDEST, 1'b0);
      end
      wait_for_records();
      ready_mode = READY_SPARSE;
      repeat (10) send_byte(ebbs_pkg::OP_JUMPDEST, 1'b0);
      send_byte(ebbs_pkg::OP_JUMPDEST, 1'b1);
      programs_sent++;
      wait_for_records();
   endtask

   task automatic test_random_programs();
      int start_bytes;
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         gaps_on = ($urandom_range(0, 3) != 0);
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         send_random_program($urandom_range(0, 9) == 0);
      end
      wait_for_records();
   endtask

   initial begin
      clear_splitter_state();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_every_opcode();
      test_push_skipping();
      test_backpressure();
      test_random_programs();
      repeat (20) @(posedge clock);
      $display("Sent %0d code bytes in %0d programs and checked %0d records.",
               bytes_sent, programs_sent, records_seen);
      $display("Covered every opcode class, push skipping and overrun, stalls and random code.");
      if (mismatch_count == 0 && expected_records.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timeout with %0d records still expected.", expected_records.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/ebbs_pkg.sv
rtl/evm_basic_block_splitter.sv
rtl/ebbs_checker.sv
dv/tb_evm_basic_block_splitter.sv
